// ----- rtl/core/rsp_pkg.sv -----
// shared types, widths and codes for the reflow setpoint profile unit
package rsp_pkg;

    // field widths
    localparam int TIME_W      = 10;
    localparam int TEMP_W      = 9;
    localparam int ELAPSED_W   = 16;
    localparam int TARGET_W    = 13;
    localparam int SEG_W       = 3;
    localparam int SUM_W       = 13;
    localparam int PROD_W      = TEMP_W + TIME_W;
    localparam int FRAC_W      = 4;
    localparam int NUM_W       = PROD_W + FRAC_W;
    localparam int CNT_W       = $clog2(NUM_W);
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 10;

    // queue between classifier and interpolator
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // profile constants
    localparam logic [TEMP_W-1:0] RSP_START_TEMP   = 9'd0;
    localparam logic [TIME_W-1:0] RSP_PEAK_SECONDS = 10'd20;

    // segment codes
    localparam logic [SEG_W-1:0] SEG_PREHEAT = 3'd0;
    localparam logic [SEG_W-1:0] SEG_SOAK    = 3'd1;
    localparam logic [SEG_W-1:0] SEG_REFLOW  = 3'd2;
    localparam logic [SEG_W-1:0] SEG_PEAK    = 3'd3;
    localparam logic [SEG_W-1:0] SEG_COOLING = 3'd4;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_PREHEAT_SECONDS = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SOAK_SECONDS    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_REFLOW_SECONDS  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_COOLING_SECONDS = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_PREHEAT_TEMP    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_SOAK_TEMP       = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_REFLOW_TEMP     = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_COOLING_TEMP    = 3'd7;

    // register reset values
    localparam logic [TIME_W-1:0] RST_PREHEAT_SECONDS = 10'd240;
    localparam logic [TIME_W-1:0] RST_SOAK_SECONDS    = 10'd90;
    localparam logic [TIME_W-1:0] RST_REFLOW_SECONDS  = 10'd90;
    localparam logic [TIME_W-1:0] RST_COOLING_SECONDS = 10'd120;
    localparam logic [TEMP_W-1:0] RST_PREHEAT_TEMP    = 9'd150;
    localparam logic [TEMP_W-1:0] RST_SOAK_TEMP       = 9'd170;
    localparam logic [TEMP_W-1:0] RST_REFLOW_TEMP     = 9'd240;
    localparam logic [TEMP_W-1:0] RST_COOLING_TEMP    = 9'd100;

    // profile settings as one bundle
    typedef struct packed {
        logic [TIME_W-1:0] preheat_seconds;
        logic [TIME_W-1:0] soak_seconds;
        logic [TIME_W-1:0] reflow_seconds;
        logic [TIME_W-1:0] cooling_seconds;
        logic [TEMP_W-1:0] preheat_temp;
        logic [TEMP_W-1:0] soak_temp;
        logic [TEMP_W-1:0] reflow_temp;
        logic [TEMP_W-1:0] cooling_temp;
    } cfg_t;

    // classified word: base*16 +/- trunc(delta*16*offset/length)
    typedef struct packed {
        logic [TEMP_W-1:0] base_temp;
        logic [TEMP_W-1:0] delta;
        logic              falling;
        logic [TIME_W-1:0] offset;
        logic [TIME_W-1:0] length;
        logic [SEG_W-1:0]  seg;
        logic              done;
    } op_t;

endpackage

// ----- rtl/core/reflow_setpoint_profile_unit.sv -----
// Reflow setpoint profile unit: elapsed seconds in, oven setpoint in 1/16 degree out.
// Each word passes through the interpolator in order: queue pop, a multiply step, a
// bit-serial restoring divider, and a load into the output register, which waits while
// the output is stalled; the next word is popped only after that load. The input side is
// taken into a two-word queue and stalls only while that queue is full, and the output
// register holds a finished word while the next one is computed. Settings must be written
// only while the unit is idle; the unit itself does not enforce this.
module reflow_setpoint_profile_unit
    import rsp_pkg::*;
#(
    parameter logic [TEMP_W-1:0] START_TEMP   = RSP_START_TEMP,
    parameter logic [TIME_W-1:0] PEAK_SECONDS = RSP_PEAK_SECONDS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [ELAPSED_W-1:0]   elapsed_seconds,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [TARGET_W-1:0]    target_temp,
    output logic                   profile_done,
    output logic [SEG_W-1:0]       segment
);

    cfg_t cfg_reg;
    op_t  front_op, head_op;
    logic q_full, q_empty, q_push, q_pop;

    // settings registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.preheat_seconds <= RST_PREHEAT_SECONDS;
            cfg_reg.soak_seconds    <= RST_SOAK_SECONDS;
            cfg_reg.reflow_seconds  <= RST_REFLOW_SECONDS;
            cfg_reg.cooling_seconds <= RST_COOLING_SECONDS;
            cfg_reg.preheat_temp    <= RST_PREHEAT_TEMP;
            cfg_reg.soak_temp       <= RST_SOAK_TEMP;
            cfg_reg.reflow_temp     <= RST_REFLOW_TEMP;
            cfg_reg.cooling_temp    <= RST_COOLING_TEMP;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_PREHEAT_SECONDS: cfg_reg.preheat_seconds <= cfg_data;
                CFG_SOAK_SECONDS:    cfg_reg.soak_seconds    <= cfg_data;
                CFG_REFLOW_SECONDS:  cfg_reg.reflow_seconds  <= cfg_data;
                CFG_COOLING_SECONDS: cfg_reg.cooling_seconds <= cfg_data;
                CFG_PREHEAT_TEMP:    cfg_reg.preheat_temp    <= cfg_data[TEMP_W-1:0];
                CFG_SOAK_TEMP:       cfg_reg.soak_temp       <= cfg_data[TEMP_W-1:0];
                CFG_REFLOW_TEMP:     cfg_reg.reflow_temp     <= cfg_data[TEMP_W-1:0];
                CFG_COOLING_TEMP:    cfg_reg.cooling_temp    <= cfg_data[TEMP_W-1:0];
                default:             cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    // input handshake into the queue
    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;

    // classifier
    rsp_front #(
        .START_TEMP   (START_TEMP),
        .PEAK_SECONDS (PEAK_SECONDS)
    ) u_front (
        .cfg             (cfg_reg),
        .elapsed_seconds (elapsed_seconds),
        .op              (front_op)
    );

    // decoupling queue
    rsp_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .push_op (front_op),
        .pop     (q_pop),
        .head_op (head_op),
        .full    (q_full),
        .empty   (q_empty)
    );

    // interpolator
    rsp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_op      (head_op),
        .empty        (q_empty),
        .pop          (q_pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .target_temp  (target_temp),
        .profile_done (profile_done),
        .segment      (segment)
    );

endmodule

// ----- rtl/core/rsp_front.sv -----
// classifier: finds the profile segment and sets up the interpolation word
module rsp_front
    import rsp_pkg::*;
#(
    parameter logic [TEMP_W-1:0] START_TEMP   = RSP_START_TEMP,
    parameter logic [TIME_W-1:0] PEAK_SECONDS = RSP_PEAK_SECONDS
)
(
    input  cfg_t                 cfg,
    input  logic [ELAPSED_W-1:0] elapsed_seconds,
    output op_t                  op
);

    logic [SUM_W-1:0]     end1, end2, end3, end4, end5;
    logic [ELAPSED_W-1:0] off1, off2, off4;
    logic [TEMP_W-1:0]    t1, t2;
    logic [TIME_W-1:0]    offset, length;
    logic [SEG_W-1:0]     seg;
    logic                 done;

    // running segment end times
    assign end1 = SUM_W'(cfg.preheat_seconds);
    assign end2 = end1 + SUM_W'(cfg.soak_seconds);
    assign end3 = end2 + SUM_W'(cfg.reflow_seconds);
    assign end4 = end3 + SUM_W'(PEAK_SECONDS);
    assign end5 = end4 + SUM_W'(cfg.cooling_seconds);

    // time into each ramp segment
    assign off1 = elapsed_seconds - ELAPSED_W'(end1);
    assign off2 = elapsed_seconds - ELAPSED_W'(end2);
    assign off4 = elapsed_seconds - ELAPSED_W'(end4);

    // segment select
    always_comb
    begin
        done   = 1'b0;
        seg    = SEG_PREHEAT;
        t1     = START_TEMP;
        t2     = cfg.preheat_temp;
        offset = elapsed_seconds[TIME_W-1:0];
        length = cfg.preheat_seconds;
        if (elapsed_seconds < ELAPSED_W'(end1))
        begin
            seg = SEG_PREHEAT;
        end
        else if (elapsed_seconds < ELAPSED_W'(end2))
        begin
            seg    = SEG_SOAK;
            t1     = cfg.preheat_temp;
            t2     = cfg.soak_temp;
            offset = off1[TIME_W-1:0];
            length = cfg.soak_seconds;
        end
        else if (elapsed_seconds < ELAPSED_W'(end3))
        begin
            seg    = SEG_REFLOW;
            t1     = cfg.soak_temp;
            t2     = cfg.reflow_temp;
            offset = off2[TIME_W-1:0];
            length = cfg.reflow_seconds;
        end
        else if (elapsed_seconds < ELAPSED_W'(end4))
        begin
            // hold: zero slope
            seg    = SEG_PEAK;
            t1     = cfg.reflow_temp;
            t2     = cfg.reflow_temp;
            offset = '0;
            length = TIME_W'(1);
        end
        else if (elapsed_seconds > ELAPSED_W'(end5))
        begin
            // past the end of cooling: zero setpoint
            seg    = SEG_COOLING;
            done   = 1'b1;
            t1     = '0;
            t2     = '0;
            offset = '0;
            length = TIME_W'(1);
        end
        else
        begin
            seg    = SEG_COOLING;
            t1     = cfg.reflow_temp;
            t2     = cfg.cooling_temp;
            offset = off4[TIME_W-1:0];
            length = cfg.cooling_seconds;
        end
    end

    // slope magnitude and sign
    assign op = '{
        base_temp: t1,
        delta:     (t2 < t1) ? (t1 - t2) : (t2 - t1),
        falling:   (t2 < t1),
        offset:    offset,
        length:    (length == '0) ? TIME_W'(1) : length,
        seg:       seg,
        done:      done
    };

endmodule

// ----- rtl/core/rsp_queue.sv -----
// two-entry queue of classified words between classifier and interpolator
module rsp_queue
    import rsp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  op_t  push_op,
    input  logic pop,
    output op_t  head_op,
    output logic full,
    output logic empty
);

    op_t               entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign full    = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign head_op = entry_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/core/rsp_back.sv -----
// interpolator: multiply, bit-serial divide, then output register
module rsp_back
    import rsp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  op_t                 head_op,
    input  logic                empty,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [TARGET_W-1:0] target_temp,
    output logic                profile_done,
    output logic [SEG_W-1:0]    segment
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_MUL    = 2'd1;
    localparam logic [1:0] ST_DIV    = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0]          state_reg, state_next;
    op_t                 op_reg;
    logic [NUM_W-1:0]    num_reg;
    logic [TIME_W-1:0]   rem_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic                out_valid_reg;
    logic [TARGET_W-1:0] target_reg;
    logic                done_reg;
    logic [SEG_W-1:0]    seg_reg;

    logic [PROD_W-1:0]   product;
    logic [TIME_W:0]     rem_shift;
    logic                rem_ge;
    logic [TIME_W-1:0]   rem_next;
    logic [NUM_W-1:0]    num_next;
    logic [TARGET_W-1:0] base16, quotient, result;
    logic                out_load;

    assign pop = (state_reg == ST_IDLE) && !empty;

    // one restoring division step
    assign product   = PROD_W'(op_reg.delta) * PROD_W'(op_reg.offset);
    assign rem_shift = {rem_reg, num_reg[NUM_W-1]};
    assign rem_ge    = (rem_shift >= {1'b0, op_reg.length});
    assign rem_next  = rem_ge ? TIME_W'(rem_shift - {1'b0, op_reg.length}) : rem_shift[TIME_W-1:0];
    assign num_next  = {num_reg[NUM_W-2:0], rem_ge};

    // setpoint from base and quotient
    assign base16   = {op_reg.base_temp, {FRAC_W{1'b0}}};
    assign quotient = num_reg[TARGET_W-1:0];
    assign result   = op_reg.falling ? (base16 - quotient) : (base16 + quotient);
    assign out_load = (state_reg == ST_FINISH) && (!out_valid_reg || !out_stall);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!empty)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (cnt_reg == CNT_W'(NUM_W - 1))
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_MUL)
            begin
                cnt_reg <= '0;
            end
            else if (state_reg == ST_DIV)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            op_reg <= head_op;
        end
        if (state_reg == ST_MUL)
        begin
            num_reg <= {product, {FRAC_W{1'b0}}};
            rem_reg <= '0;
        end
        else if (state_reg == ST_DIV)
        begin
            num_reg <= num_next;
            rem_reg <= rem_next;
        end
        if (out_load)
        begin
            target_reg <= result;
            done_reg   <= op_reg.done;
            seg_reg    <= op_reg.seg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign target_temp  = target_reg;
    assign profile_done = done_reg;
    assign segment      = seg_reg;

endmodule
